[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the disk scheduler port checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hw/rtl/sdrs_pkg.sv]
// ---------------------------------------------------------------------------
// SCAN disk request scheduler package
// Field widths, register indexes, operation codes and reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdrs_pkg;

  localparam int TRACK_W   = 8;
  localparam int DIST_W    = 9;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam int MAX_TRACKS_DEF = 256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_UPWARD = 2'd2;

  // Operation codes of an input transaction.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  // Reset values.
  localparam logic [CNT_W-1:0]   TRACK_COUNT_RST = 9'd200;
  localparam logic [TRACK_W-1:0] START_TRACK_RST = 8'd0;
  localparam logic               START_UP_RST    = 1'b1;

endpackage

[hw/rtl/scan_disk_request_scheduler.sv]
// ---------------------------------------------------------------------------
// SCAN disk request scheduler
// Elevator scheduling of pending disk tracks with a one-bit-per-track map.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   in_op_i, in_track_i
// out       source     out_valid_o / out_stall_i out_served_track_o, out_distance_o,
//                                                out_reversed_o, out_empty_res_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A serve transaction walks the pending map one track per cycle, from track
// zero up to the edge, through a single compare against the arm position,
// then its done step resolves the choice and the distance. Reset clears the
// pending map at once, in its own flip-flops, so no clearing pass is needed.
// The block stalls its input while a serve is in progress, and a finished
// serve waits in its last step only while the previous result is still held
// in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_disk_request_scheduler #(
  parameter int MAX_TRACKS = sdrs_pkg::MAX_TRACKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_op_i,
  input  logic [sdrs_pkg::TRACK_W-1:0]   in_track_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sdrs_pkg::TRACK_W-1:0]   out_served_track_o,
  output logic [sdrs_pkg::DIST_W-1:0]    out_distance_o,
  output logic                           out_reversed_o,
  output logic                           out_empty_res_o,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdrs_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  import sdrs_pkg::*;

  // Only tracks addressable by the 8-bit track field can ever be stored.
  localparam int TRACK_LIMIT = (MAX_TRACKS < 256) ? MAX_TRACKS : 256;
  localparam int IDX_W       = (TRACK_LIMIT > 1) ? $clog2(TRACK_LIMIT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [TRACK_LIMIT-1:0] pending_q, pending_d;
  logic [CNT_W-1:0]       track_count_q, track_count_d;
  logic [TRACK_W-1:0]     arm_head_q, arm_head_d;
  logic                   sweep_up_q, sweep_up_d;

  // Scan state: walking index, captured position and pre-travel, and the
  // two candidates gathered along the way.
  logic [TRACK_W-1:0]     scan_q, scan_d;
  logic [TRACK_W-1:0]     pos_q, pos_d;
  logic [TRACK_W-1:0]     pre_q, pre_d;
  logic                   ge_vld_q, ge_vld_d;
  logic [TRACK_W-1:0]     ge_trk_q, ge_trk_d;
  logic                   le_vld_q, le_vld_d;
  logic [TRACK_W-1:0]     le_trk_q, le_trk_d;

  logic                   out_valid_q, out_valid_d;
  logic [TRACK_W-1:0]     res_trk_q, res_trk_d;
  logic [DIST_W-1:0]      res_dist_q, res_dist_d;
  logic                   res_rev_q, res_rev_d;
  logic                   res_empty_q, res_empty_d;

  logic [CNT_W-1:0]       eff_count;
  logic [CNT_W-1:0]       edge_full;
  logic [TRACK_W-1:0]     edge_trk;
  logic                   in_fire;
  logic                   cfg_fire;
  logic                   hit;
  logic                   at_or_above;
  logic                   at_or_below;
  logic                   out_free;
  logic [TRACK_W-1:0]     pick_trk;
  logic [DIST_W:0]        pick_dist;
  logic                   pick_rev;

  // The register is saturated into the usable range of track counts.
  always_comb begin
    eff_count = track_count_q;
    if (eff_count < CNT_W'(2)) begin
      eff_count = CNT_W'(2);
    end
    if (eff_count > CNT_W'(TRACK_LIMIT)) begin
      eff_count = CNT_W'(TRACK_LIMIT);
    end
  end

  assign edge_full = eff_count - CNT_W'(1);
  assign edge_trk  = edge_full[TRACK_W-1:0];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // The one compare unit of the scan: current index against the arm.
  assign hit         = pending_q[scan_q[IDX_W-1:0]];
  assign at_or_above = (scan_q >= pos_q);
  assign at_or_below = !at_or_above || (scan_q == pos_q);

  // Resolution of the gathered candidates. When nothing lies ahead, the
  // candidate on the other side is exactly the nearest track after reversal.
  always_comb begin
    pick_trk  = ge_trk_q;
    pick_rev  = 1'b0;
    pick_dist = {2'b00, pre_q} + {2'b00, ge_trk_q} - {2'b00, pos_q};
    if (sweep_up_q) begin
      if (!ge_vld_q) begin
        pick_trk  = le_trk_q;
        pick_rev  = 1'b1;
        pick_dist = {2'b00, pre_q} + {2'b00, edge_trk} - {2'b00, pos_q}
                  + {2'b00, edge_trk} - {2'b00, le_trk_q};
      end
    end else begin
      if (le_vld_q) begin
        pick_trk  = le_trk_q;
        pick_dist = {2'b00, pre_q} + {2'b00, pos_q} - {2'b00, le_trk_q};
      end else begin
        pick_rev  = 1'b1;
        pick_dist = {2'b00, pre_q} + {2'b00, pos_q} + {2'b00, ge_trk_q};
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    pending_d     = pending_q;
    track_count_d = track_count_q;
    arm_head_d    = arm_head_q;
    sweep_up_d    = sweep_up_q;
    scan_d        = scan_q;
    pos_d         = pos_q;
    pre_d         = pre_q;
    ge_vld_d      = ge_vld_q;
    ge_trk_d      = ge_trk_q;
    le_vld_d      = le_vld_q;
    le_trk_d      = le_trk_q;
    out_valid_d   = out_valid_q;
    res_trk_d     = res_trk_q;
    res_dist_d    = res_dist_q;
    res_rev_d     = res_rev_q;
    res_empty_d   = res_empty_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_TRACK_COUNT:  track_count_d = cfg_data_i;
        CFG_START_TRACK:  arm_head_d    = cfg_data_i[TRACK_W-1:0];
        CFG_START_UPWARD: sweep_up_d    = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op_i == OP_ADD) begin
            // Tracks at or above the effective count are dropped.
            if ({1'b0, in_track_i} < eff_count) begin
              pending_d[in_track_i[IDX_W-1:0]] = 1'b1;
            end
          end else begin
            // An arm beyond the edge first travels down to the edge.
            if (arm_head_q > edge_trk) begin
              pos_d = edge_trk;
              pre_d = arm_head_q - edge_trk;
            end else begin
              pos_d = arm_head_q;
              pre_d = '0;
            end
            scan_d   = '0;
            ge_vld_d = 1'b0;
            le_vld_d = 1'b0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Keep the first pending track at or above the arm and the last one
        // at or below it.
        if (hit && at_or_above && !ge_vld_q) begin
          ge_vld_d = 1'b1;
          ge_trk_d = scan_q;
        end
        if (hit && at_or_below) begin
          le_vld_d = 1'b1;
          le_trk_d = scan_q;
        end
        if (scan_q == edge_trk) begin
          state_d = ST_DONE;
        end else begin
          scan_d = scan_q + TRACK_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (!ge_vld_q && !le_vld_q) begin
            // Nothing pending: report an empty queue, arm state untouched.
            res_trk_d   = '0;
            res_dist_d  = '0;
            res_rev_d   = 1'b0;
            res_empty_d = 1'b1;
          end else begin
            res_trk_d   = pick_trk;
            res_dist_d  = pick_dist[DIST_W-1:0];
            res_rev_d   = pick_rev;
            res_empty_d = 1'b0;
            pending_d[pick_trk[IDX_W-1:0]] = 1'b0;
            arm_head_d  = pick_trk;
            if (pick_rev) begin
              sweep_up_d = !sweep_up_q;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pending_q     <= '0;
      track_count_q <= TRACK_COUNT_RST;
      arm_head_q    <= START_TRACK_RST;
      sweep_up_q    <= START_UP_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      pending_q     <= pending_d;
      track_count_q <= track_count_d;
      arm_head_q    <= arm_head_d;
      sweep_up_q    <= sweep_up_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    pos_q       <= pos_d;
    pre_q       <= pre_d;
    ge_vld_q    <= ge_vld_d;
    ge_trk_q    <= ge_trk_d;
    le_vld_q    <= le_vld_d;
    le_trk_q    <= le_trk_d;
    res_trk_q   <= res_trk_d;
    res_dist_q  <= res_dist_d;
    res_rev_q   <= res_rev_d;
    res_empty_q <= res_empty_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_served_track_o = res_trk_q;
  assign out_distance_o     = res_dist_q;
  assign out_reversed_o     = res_rev_q;
  assign out_empty_res_o    = res_empty_q;

endmodule

[hw/rtl/sdrs_checker.sv]
// ---------------------------------------------------------------------------
// SCAN disk request scheduler checker
// Port-level assertions, attached to the top level by a bind statement.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sdrs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_obs_i,
  input logic                         in_op_i,
  input logic                         out_valid_obs_i,
  input logic                         out_stall_i,
  input logic [sdrs_pkg::TRACK_W-1:0] served_track_obs_i,
  input logic [sdrs_pkg::DIST_W-1:0]  distance_obs_i,
  input logic                         reversed_obs_i,
  input logic                         empty_res_obs_i
);

  import sdrs_pkg::*;

  logic serve_fire;

  assign serve_fire = in_valid_i && !in_stall_obs_i && (in_op_i == OP_SERVE);

  // A held result keeps its valid and its payload.
  `SDRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_obs_i && out_stall_i,
    out_valid_obs_i && $stable(served_track_obs_i) && $stable(distance_obs_i)
    && $stable(reversed_obs_i) && $stable(empty_res_obs_i))

  // An empty-queue result carries no track, distance or reversal.
  `SDRS_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_obs_i && empty_res_obs_i,
    (served_track_obs_i == '0) && (distance_obs_i == '0) && !reversed_obs_i)

  // A serve always occupies the block for at least the following cycle.
  `SDRS_ASSERT_NEXT(a_serve_busy, clk_i, rst_ni, serve_fire, in_stall_obs_i)

  // A new result only appears at the end of a serve in progress.
  `SDRS_ASSERT_NOW(a_result_from_serve, clk_i, rst_ni, $rose(out_valid_obs_i),
    $past(in_stall_obs_i))

endmodule

bind scan_disk_request_scheduler sdrs_checker u_sdrs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_obs_i     (in_stall_o),
  .in_op_i            (in_op_i),
  .out_valid_obs_i    (out_valid_o),
  .out_stall_i        (out_stall_i),
  .served_track_obs_i (out_served_track_o),
  .distance_obs_i     (out_distance_o),
  .reversed_obs_i     (out_reversed_o),
  .empty_res_obs_i    (out_empty_res_o)
);

[bench/scan_disk_request_scheduler_checker.sv]
// ---------------------------------------------------------------------------
// SCAN disk request scheduler checker
// Watches the request, result and configuration channels, predicts every
// service from its own copy of the pending map and arm, and compares results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_disk_request_scheduler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           in_op_i,
  input  logic [sdrs_pkg::TRACK_W-1:0]   in_track_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [sdrs_pkg::TRACK_W-1:0]   out_served_track_i,
  input  logic [sdrs_pkg::DIST_W-1:0]    out_distance_i,
  input  logic                           out_reversed_i,
  input  logic                           out_empty_res_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [sdrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdrs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             expected_left_o,
  output int                             services_o,
  output int                             empties_o,
  output int                             reversals_o
);
  import sdrs_pkg::*;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [DIST_W-1:0]  distance;
    logic               rev;
    logic               empty;
  } service_t;

  localparam int MAX_PRINTED = 40;

  logic [255:0]       pending_tracks;
  logic [CNT_W-1:0]   track_count;
  logic [TRACK_W-1:0] arm_pos;
  logic               heading_up;
  service_t           service_q[$];

  int fail_count   = 0;
  int services     = 0;
  int empties      = 0;
  int reversals    = 0;
  int pending_left = 0;

  assign fail_count_o    = fail_count;
  assign expected_left_o = pending_left;
  assign services_o      = services;
  assign empties_o       = empties;
  assign reversals_o     = reversals;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Counts below 2 or above 256 are saturated by the scheduler.
  function automatic int usable_tracks();
    if (track_count < 2) begin
      return 2;
    end
    if (track_count > 256) begin
      return 256;
    end
    return int'(track_count);
  endfunction

  // Picks the next track by the elevator rule, clears it and moves the arm.
  function automatic service_t take_next_track();
    int       top_trk;
    int       pos;
    int       travel;
    int       found;
    bit       any;
    service_t res;
    top_trk = usable_tracks() - 1;
    res     = '0;
    any     = 1'b0;
    for (int i = 0; i <= top_trk; i++) begin
      if (pending_tracks[i]) begin
        any = 1'b1;
      end
    end
    if (!any) begin
      res.empty = 1'b1;
      return res;
    end
    pos    = int'(arm_pos);
    travel = 0;
    found  = -1;
    // An arm left beyond a shrunken edge first travels back to the edge.
    if (pos > top_trk) begin
      travel = pos - top_trk;
      pos    = top_trk;
    end
    if (heading_up) begin
      for (int i = pos; i <= top_trk && found < 0; i++) begin
        if (pending_tracks[i]) begin
          found = i;
        end
      end
      if (found >= 0) begin
        travel += found - pos;
      end else begin
        for (int i = pos - 1; i >= 0 && found < 0; i--) begin
          if (pending_tracks[i]) begin
            found = i;
          end
        end
        travel     += (top_trk - pos) + (top_trk - found);
        res.rev     = 1'b1;
        heading_up  = 1'b0;
      end
    end else begin
      for (int i = pos; i >= 0 && found < 0; i--) begin
        if (pending_tracks[i]) begin
          found = i;
        end
      end
      if (found >= 0) begin
        travel += pos - found;
      end else begin
        for (int i = pos + 1; i <= top_trk && found < 0; i++) begin
          if (pending_tracks[i]) begin
            found = i;
          end
        end
        travel     += pos + found;
        res.rev     = 1'b1;
        heading_up  = 1'b1;
      end
    end
    pending_tracks[found] = 1'b0;
    arm_pos      = found[TRACK_W-1:0];
    res.track    = found[TRACK_W-1:0];
    res.distance = travel[DIST_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    service_t want;
    if (!rst_ni) begin
      pending_tracks = '0;
      track_count    = TRACK_COUNT_RST;
      arm_pos        = START_TRACK_RST;
      heading_up     = START_UP_RST;
      service_q.delete();
      pending_left   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (service_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, track %0d",
                                    out_served_track_i));
        end else begin
          want = service_q.pop_front();
          services++;
          if (out_empty_res_i) empties++;
          if (out_reversed_i) reversals++;
          if (out_served_track_i !== want.track) begin
            report_mismatch($sformatf("served_track %0d, expected %0d",
                                      out_served_track_i, want.track));
          end
          if (out_distance_i !== want.distance) begin
            report_mismatch($sformatf("distance %0d, expected %0d (track %0d)",
                                      out_distance_i, want.distance, want.track));
          end
          if (out_reversed_i !== want.rev) begin
            report_mismatch($sformatf("reversed %0b, expected %0b (track %0d)",
                                      out_reversed_i, want.rev, want.track));
          end
          if (out_empty_res_i !== want.empty) begin
            report_mismatch($sformatf("empty_res %0b, expected %0b",
                                      out_empty_res_i, want.empty));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TRACK_COUNT:  track_count = cfg_data_i[CNT_W-1:0];
          CFG_START_TRACK:  arm_pos     = cfg_data_i[TRACK_W-1:0];
          CFG_START_UPWARD: heading_up  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_op_i == OP_SERVE) begin
          service_q.push_back(take_next_track());
        end else if (int'(in_track_i) < usable_tracks()) begin
          pending_tracks[in_track_i] = 1'b1;
        end
      end
      pending_left = service_q.size();
    end
  end

endmodule

[bench/scan_disk_request_scheduler_tb.sv]
// ---------------------------------------------------------------------------
// SCAN disk request scheduler testbench
// Drives add and serve transactions under a series of register settings,
// with random gaps and output stalls, and leaves all checking to the checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_disk_request_scheduler_tb;
  import sdrs_pkg::*;

  // A serve walks up to 256 tracks, so the whole run stays well below this.
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 185;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // All inputs of the block start at known values.
  logic                 in_valid  = 1'b0;
  logic                 in_op     = OP_ADD;
  logic [TRACK_W-1:0]   in_track  = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRACK_COUNT;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  logic               in_stall;
  logic               out_valid;
  logic [TRACK_W-1:0] out_served_track;
  logic [DIST_W-1:0]  out_distance;
  logic               out_reversed;
  logic               out_empty_res;
  logic               cfg_ready;

  int fail_count;
  int expected_left;
  int services;
  int empties;
  int reversals;

  int  cycle_count = 0;
  int  requests    = 0;
  int  settings    = 1;
  // While calm is set neither side idles nor stalls.
  bit  calm        = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scan_disk_request_scheduler dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_op_i            (in_op),
    .in_track_i         (in_track),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_served_track_o (out_served_track),
    .out_distance_o     (out_distance),
    .out_reversed_o     (out_reversed),
    .out_empty_res_o    (out_empty_res),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  scan_disk_request_scheduler_checker checker_i (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .in_op_i            (in_op),
    .in_track_i         (in_track),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .out_served_track_i (out_served_track),
    .out_distance_i     (out_distance),
    .out_reversed_i     (out_reversed),
    .out_empty_res_i    (out_empty_res),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .expected_left_o    (expected_left),
    .services_o         (services),
    .empties_o          (empties),
    .reversals_o        (reversals)
  );

  // Unless calm is set, the result side stalls in roughly 29 percent of cycles,
  // independently of what the block is doing, so stalls land on every step of a service.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, expected_left);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one request transaction and holds it until the block takes it.
  // A random gap may come first; valid is only ever lowered in the step of an
  // acceptance, so it is never dropped and raised within the same time step.
  task automatic put_request(input logic op, input logic [TRACK_W-1:0] trk);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_track <= trk;
    do @(posedge clk); while (in_stall);
    requests++;
  endtask

  // Stops offering requests until every predicted result has been taken.
  // The checker updates its count at the rising edge, so it is read at the
  // falling edge. The extra cycles cover an add that may still be in flight.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic configure(input logic [CNT_W-1:0] count, input logic [TRACK_W-1:0] start,
                           input logic up);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DAT_W-1:0] val [3];
    idx[0] = CFG_TRACK_COUNT;
    idx[1] = CFG_START_TRACK;
    idx[2] = CFG_START_UPWARD;
    val[0] = count;
    val[1] = {1'b0, start};
    val[2] = {8'd0, up};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0]   cnt_set;
    logic [TRACK_W-1:0] start_set;
    logic               up_set;
    logic [TRACK_W-1:0] trk;
    logic [TRACK_W-1:0] last_added;
    int                 usable;
    int                 pause_at;
    int                 pick;

    last_added = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: 200 tracks, arm at 0, upward.
    // A serve with nothing pending reports an empty queue.
    put_request(OP_SERVE, 8'hFF);
    // Lowest and edge tracks, two adds past the count that must be dropped,
    // and a repeated add that merges with the one already pending.
    put_request(OP_ADD, 8'd0);
    put_request(OP_ADD, 8'd199);
    put_request(OP_ADD, 8'd255);
    put_request(OP_ADD, 8'd200);
    put_request(OP_ADD, 8'd0);
    // A request at the arm is served without travel, then a full sweep to the
    // edge, then the queue is empty again as the dropped tracks never counted.
    put_request(OP_SERVE, 8'h00);
    put_request(OP_SERVE, 8'h5A);
    put_request(OP_SERVE, 8'hA5);
    // With the arm sitting on the edge the next serve reverses on the spot.
    put_request(OP_ADD, 8'd150);
    put_request(OP_ADD, 8'd50);
    put_request(OP_SERVE, 8'h0F);
    put_request(OP_SERVE, 8'hF0);
    // Heading down with nothing below: travel to track zero, then back up.
    put_request(OP_ADD, 8'd85);
    put_request(OP_ADD, 8'd170);
    put_request(OP_SERVE, 8'h33);
    put_request(OP_SERVE, 8'hCC);
    // Left pending so that it sits above the count once the count shrinks.
    put_request(OP_ADD, 8'd190);
    wait_for_results();

    // A count of zero saturates to two tracks and leaves the arm past the edge,
    // so the first serve includes the trip back down to the edge.
    configure(9'd0, 8'd255, 1'b1);
    put_request(OP_ADD, 8'd1);
    put_request(OP_ADD, 8'd0);
    put_request(OP_ADD, 8'd150);
    put_request(OP_SERVE, 8'hFF);
    put_request(OP_SERVE, 8'h00);
    wait_for_results();

    // Random part: each phase picks a setting, extremes first, and mixes adds
    // and serves so that the map stays partly filled and both sweep directions
    // and reversals keep occurring. Tracks left over from a previous phase
    // carry across, including those above a count that has since shrunk.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cnt_set = 9'd16;  start_set = 8'd5;   up_set = 1'b0; end
        1: begin cnt_set = 9'd256; start_set = 8'd255; up_set = 1'b1; end
        2: begin cnt_set = 9'd1;   start_set = 8'd200; up_set = 1'b1; end
        3: begin cnt_set = 9'd40;  start_set = 8'd20;  up_set = 1'b1; end
        4: begin cnt_set = 9'd511; start_set = 8'd0;   up_set = 1'b0; end
        5: begin cnt_set = 9'd3;   start_set = 8'd255; up_set = 1'b0; end
        default: begin
          cnt_set   = 9'($urandom_range(2, 64));
          start_set = 8'($urandom_range(255));
          up_set    = 1'($urandom_range(1));
        end
      endcase
      configure(cnt_set, start_set, up_set);
      usable = (cnt_set < 2) ? 2 : ((cnt_set > 256) ? 256 : int'(cnt_set));
      // One phase runs with no idling on either side at all.
      calm     = (p == 3);
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) begin
          wait_for_results();
        end
        if ($urandom_range(99) < 52) begin
          pick = $urandom_range(99);
          if (pick < 75) begin
            trk = 8'($urandom_range(usable - 1));
          end else if (pick < 85) begin
            trk = last_added;
          end else if (pick < 93) begin
            trk = 8'($urandom_range(255));
          end else begin
            trk = 8'(usable - 1);
          end
          last_added = trk;
          put_request(OP_ADD, trk);
        end else begin
          put_request(OP_SERVE, 8'($urandom_range(255)));
        end
      end
      wait_for_results();
      calm = 1'b0;
    end

    $display("Ran %0d request transactions over %0d register settings.",
             requests, settings);
    $display("Checked %0d results: %0d with an empty queue, %0d with a reversal.",
             services, empties, reversals);
    if (fail_count == 0 && expected_left == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[scan_disk_request_scheduler.f]
+incdir+hw/rtl
hw/rtl/sdrs_pkg.sv
hw/rtl/scan_disk_request_scheduler.sv
hw/rtl/sdrs_checker.sv
bench/scan_disk_request_scheduler_checker.sv
bench/scan_disk_request_scheduler_tb.sv
